/* design/stl_pkg.sv */
// Shared types, codes and character tables for the source token lexer.
package stl_pkg;

	localparam int LEN_W       = 16;
	localparam int KIND_W      = 5;
	localparam int OUT_POS_W   = 16;
	localparam int POS_WIDTH   = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_KW      = 5;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// Token kind codes
	localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd10;
	localparam logic [KIND_W-1:0] KIND_INT    = 5'd18;
	localparam logic [KIND_W-1:0] KIND_STRING = 5'd19;
	localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd20;
	localparam logic [KIND_W-1:0] KIND_KW0    = 5'd21;
	localparam logic [KIND_W-1:0] KIND_EOF    = 5'd26;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd27;

	// Characters with a role of their own
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_BANG  = "!";
	localparam logic [7:0] CH_GT    = ">";
	localparam logic [7:0] CH_LT    = "<";
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Operator index of the pending operator
	localparam logic [1:0] OP_EQ   = 2'd0;
	localparam logic [1:0] OP_BANG = 2'd1;
	localparam logic [1:0] OP_GT   = 2'd2;
	localparam logic [1:0] OP_LT   = 2'd3;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_OP,
		MODE_NUM,
		MODE_IDENT,
		MODE_STR
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]    token_kind;
		logic [OUT_POS_W-1:0] start_pos;
		logic [LEN_W-1:0]     token_length;
		logic                 length_saturated;
		logic                 last_of_run;
	} out_item_t;

	// Up to two tokens caused by one item
	typedef struct packed {
		out_item_t tok0;
		out_item_t tok1;
		logic      two;
	} bundle_t;

	// Character class of the incoming byte
	typedef struct packed {
		logic              ws;
		logic              sym;
		logic [KIND_W-1:0] sym_kind;
		logic              op;
		logic [1:0]        op_idx;
		logic              digit;
		logic              alpha;
		logic              quote;
		logic              eq;
	} class_t;

	function automatic class_t classify(input logic [7:0] c);
		class_t r;
		r          = '0;
		r.ws       = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
		r.digit    = (c >= "0") && (c <= "9");
		r.alpha    = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
		r.quote    = (c == CH_QUOTE);
		r.eq       = (c == CH_EQ);
		r.sym      = 1'b1;
		case (c)
			"(":     r.sym_kind = 5'd0;
			")":     r.sym_kind = 5'd1;
			"{":     r.sym_kind = 5'd2;
			"}":     r.sym_kind = 5'd3;
			";":     r.sym_kind = 5'd4;
			"+":     r.sym_kind = 5'd5;
			"-":     r.sym_kind = 5'd6;
			"*":     r.sym_kind = 5'd7;
			"/":     r.sym_kind = 5'd8;
			"%":     r.sym_kind = 5'd9;
			default: r.sym = 1'b0;
		endcase
		r.op = 1'b1;
		case (c)
			CH_EQ:   r.op_idx = OP_EQ;
			CH_BANG: r.op_idx = OP_BANG;
			CH_GT:   r.op_idx = OP_GT;
			CH_LT:   r.op_idx = OP_LT;
			default: r.op = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input int k);
		logic [2:0] r;
		case (k)
			0:       r = 3'd3;
			1:       r = 3'd6;
			2:       r = 3'd4;
			3:       r = 3'd4;
			default: r = 3'd5;
		endcase
		return r;
	endfunction

	// Keyword text: int string bool true false
	function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			0: case (i)
				3'd0: r = "i";
				3'd1: r = "n";
				3'd2: r = "t";
				default: r = 8'h00;
			endcase
			1: case (i)
				3'd0: r = "s";
				3'd1: r = "t";
				3'd2: r = "r";
				3'd3: r = "i";
				3'd4: r = "n";
				3'd5: r = "g";
				default: r = 8'h00;
			endcase
			2: case (i)
				3'd0: r = "b";
				3'd1: r = "o";
				3'd2: r = "o";
				3'd3: r = "l";
				default: r = 8'h00;
			endcase
			3: case (i)
				3'd0: r = "t";
				3'd1: r = "r";
				3'd2: r = "u";
				3'd3: r = "e";
				default: r = 8'h00;
			endcase
			default: case (i)
				3'd0: r = "f";
				3'd1: r = "a";
				3'd2: r = "l";
				3'd3: r = "s";
				3'd4: r = "e";
				default: r = 8'h00;
			endcase
		endcase
		return r;
	endfunction

	// Drop keywords that cannot match once character c lands at index cnt
	function automatic logic [NUM_KW-1:0] kw_next(input logic [NUM_KW-1:0] cand,
			input logic [LEN_W-1:0] cnt, input logic [7:0] c);
		logic [NUM_KW-1:0] r;
		r = cand;
		for (int k = 0; k < NUM_KW; k++) begin
			if ((cnt >= LEN_W'(kw_len(k))) || (kw_char(k, cnt[2:0]) != c)) begin
				r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic logic [KIND_W-1:0] ident_kind(input logic [NUM_KW-1:0] cand,
			input logic [LEN_W-1:0] cnt, input logic ovf);
		logic [KIND_W-1:0] r;
		r = KIND_IDENT;
		// lowest matching keyword wins
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (cand[k] && (cnt == LEN_W'(kw_len(k)))) begin
				r = KIND_KW0 + KIND_W'(k);
			end
		end
		if (ovf) begin
			r = KIND_IDENT;
		end
		return r;
	endfunction

endpackage

/* design/stl_front.sv */
// Front end: classifies each character, tracks the scan state, builds token bundles.
module stl_front #(
	parameter int POS_WIDTH = stl_pkg::POS_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stl_pkg::in_item_t item,
	input  logic              take,
	output logic              push,
	output stl_pkg::bundle_t  bundle
);

	stl_pkg::mode_t                 mode_q, mode_d;
	logic [1:0]                     pend_q, pend_d;
	logic [POS_WIDTH-1:0]           start_q, start_d;
	logic [stl_pkg::LEN_W-1:0]      cnt_q, cnt_d;
	logic                           ovf_q, ovf_d;
	logic [POS_WIDTH-1:0]           pos_q, pos_d;
	logic [stl_pkg::NUM_KW-1:0]     cand_q, cand_d;

	stl_pkg::class_t                cls;
	logic                           idle_path;
	logic [stl_pkg::KIND_W-1:0]     op_kind;
	logic                           close_vld;
	stl_pkg::out_item_t             close_tok;
	logic                           sec_vld;
	stl_pkg::out_item_t             sec_tok;

	// Classification of the incoming byte
	always_comb begin
		cls       = stl_pkg::classify(item.ch);
		op_kind   = stl_pkg::KIND_ASSIGN + stl_pkg::KIND_W'({pend_q, 1'b0});
		idle_path = !item.end_of_input &&
			((mode_q == stl_pkg::MODE_IDLE) ||
			 ((mode_q == stl_pkg::MODE_OP) && !cls.eq) ||
			 ((mode_q == stl_pkg::MODE_NUM) && !cls.digit) ||
			 ((mode_q == stl_pkg::MODE_IDENT) && !(cls.digit || cls.alpha)));
	end

	// Next scan state
	always_comb begin
		mode_d  = mode_q;
		pend_d  = pend_q;
		start_d = start_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		pos_d   = pos_q;
		cand_d  = cand_q;
		if (item.end_of_input) begin
			mode_d  = stl_pkg::MODE_IDLE;
			pend_d  = stl_pkg::OP_EQ;
			start_d = '0;
			cnt_d   = '0;
			ovf_d   = 1'b0;
			pos_d   = '0;
			cand_d  = '1;
		end else begin
			pos_d = pos_q + POS_WIDTH'(1);
			unique case (mode_q)
				stl_pkg::MODE_OP: begin
					if (cls.eq) begin
						mode_d = stl_pkg::MODE_IDLE;
					end
				end
				stl_pkg::MODE_NUM: begin
					if (cls.digit) begin
						if (cnt_q == stl_pkg::LEN_MAX) ovf_d = 1'b1;
						else cnt_d = cnt_q + 1'b1;
					end
				end
				stl_pkg::MODE_IDENT: begin
					if (cls.digit || cls.alpha) begin
						cand_d = stl_pkg::kw_next(cand_q, cnt_q, item.ch);
						if (cnt_q == stl_pkg::LEN_MAX) ovf_d = 1'b1;
						else cnt_d = cnt_q + 1'b1;
					end
				end
				stl_pkg::MODE_STR: begin
					if (cls.quote) begin
						mode_d = stl_pkg::MODE_IDLE;
					end else if (cnt_q == stl_pkg::LEN_MAX) begin
						ovf_d = 1'b1;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			// character seen with no token open
			if (idle_path) begin
				mode_d = stl_pkg::MODE_IDLE;
				if (cls.op) begin
					mode_d  = stl_pkg::MODE_OP;
					start_d = pos_q;
					cnt_d   = '0;
					ovf_d   = 1'b0;
					pend_d  = cls.op_idx;
				end else if (cls.digit) begin
					mode_d  = stl_pkg::MODE_NUM;
					start_d = pos_q;
					cnt_d   = stl_pkg::LEN_W'(1);
					ovf_d   = 1'b0;
				end else if (cls.quote) begin
					mode_d  = stl_pkg::MODE_STR;
					start_d = pos_q + POS_WIDTH'(1);
					cnt_d   = '0;
					ovf_d   = 1'b0;
				end else if (cls.alpha) begin
					mode_d  = stl_pkg::MODE_IDENT;
					start_d = pos_q;
					cnt_d   = stl_pkg::LEN_W'(1);
					ovf_d   = 1'b0;
					cand_d  = stl_pkg::kw_next('1, '0, item.ch);
				end
			end
		end
	end

	// Tokens caused by this item: one closing the open lexeme, one more after it
	always_comb begin
		close_vld                  = 1'b0;
		close_tok.token_kind       = stl_pkg::KIND_INT;
		close_tok.start_pos        = stl_pkg::OUT_POS_W'(start_q);
		close_tok.token_length     = cnt_q;
		close_tok.length_saturated = ovf_q;
		close_tok.last_of_run      = 1'b0;
		unique case (mode_q)
			stl_pkg::MODE_OP: begin
				close_vld                  = 1'b1;
				close_tok.token_kind       = op_kind;
				close_tok.token_length     = stl_pkg::LEN_W'(1);
				close_tok.length_saturated = 1'b0;
				if (!item.end_of_input && cls.eq) begin
					close_tok.token_kind   = op_kind + 1'b1;
					close_tok.token_length = stl_pkg::LEN_W'(2);
				end
			end
			stl_pkg::MODE_NUM: begin
				close_vld            = item.end_of_input || !cls.digit;
				close_tok.token_kind = stl_pkg::KIND_INT;
			end
			stl_pkg::MODE_IDENT: begin
				close_vld            = item.end_of_input || !(cls.digit || cls.alpha);
				close_tok.token_kind = stl_pkg::ident_kind(cand_q, cnt_q, ovf_q);
			end
			stl_pkg::MODE_STR: begin
				close_vld            = item.end_of_input || cls.quote;
				close_tok.token_kind = item.end_of_input ? stl_pkg::KIND_ERROR
					: stl_pkg::KIND_STRING;
			end
			default: begin
			end
		endcase

		sec_tok.last_of_run = 1'b1;
		if (item.end_of_input) begin
			sec_vld                  = 1'b1;
			sec_tok.token_kind       = stl_pkg::KIND_EOF;
			sec_tok.start_pos        = stl_pkg::OUT_POS_W'(pos_q);
			sec_tok.token_length     = '0;
			sec_tok.length_saturated = 1'b0;
		end else begin
			sec_vld = idle_path &&
				(cls.sym || !(cls.ws || cls.op || cls.digit || cls.quote || cls.alpha));
			sec_tok.token_kind       = cls.sym ? cls.sym_kind : stl_pkg::KIND_ERROR;
			sec_tok.start_pos        = stl_pkg::OUT_POS_W'(pos_q);
			sec_tok.token_length     = stl_pkg::LEN_W'(1);
			sec_tok.length_saturated = 1'b0;
		end

		close_tok.last_of_run = !sec_vld;
		if (close_vld) begin
			bundle.tok0 = close_tok;
			bundle.tok1 = sec_tok;
			bundle.two  = sec_vld;
		end else begin
			bundle.tok0 = sec_tok;
			bundle.tok1 = sec_tok;
			bundle.two  = 1'b0;
		end
		push = take && (close_vld || sec_vld);
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stl_pkg::MODE_IDLE;
			pend_q  <= stl_pkg::OP_EQ;
			start_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			cand_q  <= '1;
		end else if (take) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			start_q <= start_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			pos_q   <= pos_d;
			cand_q  <= cand_d;
		end
	end

endmodule

/* design/stl_queue.sv */
// Short queue of token bundles between the front end and the back end.
module stl_queue #(
	parameter int DEPTH = stl_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stl_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output stl_pkg::bundle_t head
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	stl_pkg::bundle_t   mem_q [DEPTH];
	logic [IDX_W-1:0]   wr_q;
	logic [IDX_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/stl_back.sv */
// Back end: splits each bundle into single tokens behind an output register.
module stl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  stl_pkg::bundle_t   head,
	output logic               pop,
	output logic               tok_valid,
	input  logic               tok_ready,
	output stl_pkg::out_item_t tok_item
);

	logic               out_vld_q;
	stl_pkg::out_item_t out_q;
	logic               second_q;
	logic               load;

	// Load a new token when the output register is free or being taken
	assign load      = !out_vld_q || tok_ready;
	assign pop       = load && not_empty && (second_q || !head.two);
	assign tok_valid = out_vld_q;
	assign tok_item  = out_q;

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_q <= second_q ? head.tok1 : head.tok0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			second_q  <= 1'b0;
		end else if (load) begin
			out_vld_q <= not_empty;
			if (not_empty) begin
				second_q <= !second_q && head.two;
			end
		end
	end

endmodule

/* design/source_token_lexer_core.sv */
// Streaming lexer top level: one character per item in, tokens out.
// Throughput: one item per cycle in while the queue is not full; one token per cycle
// out while tok_ready is high, so an item that yields two tokens holds the output register for both.
// Path: an item's bundle is written into the queue when the item is accepted, then loaded
// into the output register; a full queue holds off input.
// Reset clears the scan state, character position, token queue and output valid.
module source_token_lexer_core #(
	parameter int POS_WIDTH   = stl_pkg::POS_WIDTH,
	parameter int QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  stl_pkg::in_item_t  src_item,
	output logic               tok_valid,
	input  logic               tok_ready,
	output stl_pkg::out_item_t tok_item
);

	logic             take;
	logic             push;
	logic             full;
	logic             pop;
	logic             not_empty;
	stl_pkg::bundle_t bundle;
	stl_pkg::bundle_t head;

	assign src_ready = !full;
	assign take      = src_valid && src_ready;

	stl_front #(
		.POS_WIDTH(POS_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (src_item),
		.take   (take),
		.push   (push),
		.bundle (bundle)
	);

	stl_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	stl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule

/* dv/tb_source_token_lexer_core.sv */
// Testbench for source_token_lexer_core: directed and random character streams, scoreboard check.
module tb_source_token_lexer_core;
	import stl_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int RANDOM_FIRST  = 500;
	localparam int RANDOM_SECOND = 650;

	// Predicts the token stream and checks tokens in arrival order
	class token_tracker;
		mode_t                mode;
		logic [1:0]           op_held;
		logic [POS_WIDTH-1:0] lex_start;
		logic [LEN_W-1:0]     lex_len;
		logic                 lex_sat;
		logic [POS_WIDTH-1:0] char_pos;
		logic [NUM_KW-1:0]    kw_alive;
		out_item_t            tokens_due[$];
		int                   errors;
		string                kw_word[NUM_KW];
		string                sym_text;
		string                op_text;

		function new();
			kw_word  = '{"int", "string", "bool", "true", "false"};
			sym_text = "(){};+-*/%";
			op_text  = "=!><";
			errors   = 0;
			clear();
		endfunction

		function void clear();
			mode      = MODE_IDLE;
			op_held   = OP_EQ;
			lex_start = '0;
			lex_len   = '0;
			lex_sat   = 1'b0;
			char_pos  = '0;
			kw_alive  = '1;
		endfunction

		function bit is_digit(logic [7:0] c);
			return (c >= "0") && (c <= "9");
		endfunction

		function bit is_alpha(logic [7:0] c);
			return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
		endfunction

		function void add_token(logic [KIND_W-1:0] kind, logic [POS_WIDTH-1:0] start,
				logic [LEN_W-1:0] len, logic sat);
			out_item_t t;
			t.token_kind       = kind;
			t.start_pos        = OUT_POS_W'(start);
			t.token_length     = len;
			t.length_saturated = sat;
			t.last_of_run      = 1'b0;
			tokens_due.push_back(t);
		endfunction

		// Length sticks at its maximum and raises the saturation flag
		function void lengthen();
			if (lex_len == LEN_MAX) begin
				lex_sat = 1'b1;
			end else begin
				lex_len++;
			end
		endfunction

		// Keep only the keywords that still agree with the word so far
		function void word_char(logic [7:0] c);
			for (int k = 0; k < NUM_KW; k++) begin
				if ((lex_len >= kw_word[k].len()) || (kw_word[k][lex_len] != c)) begin
					kw_alive[k] = 1'b0;
				end
			end
			lengthen();
		endfunction

		function logic [KIND_W-1:0] word_kind();
			if (lex_sat) begin
				return KIND_IDENT;
			end
			for (int k = 0; k < NUM_KW; k++) begin
				if (kw_alive[k] && (lex_len == kw_word[k].len())) begin
					return KIND_KW0 + KIND_W'(k);
				end
			end
			return KIND_IDENT;
		endfunction

		function void open_lexeme(mode_t m, logic [POS_WIDTH-1:0] start);
			mode      = m;
			lex_start = start;
			lex_len   = '0;
			lex_sat   = 1'b0;
		endfunction

		// Character seen with no lexeme open
		function void fresh_char(logic [7:0] c);
			mode = MODE_IDLE;
			if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL)) begin
				return;
			end
			for (int k = 0; k < sym_text.len(); k++) begin
				if (sym_text[k] == c) begin
					add_token(KIND_W'(k), char_pos, 1, 1'b0);
					return;
				end
			end
			for (int k = 0; k < op_text.len(); k++) begin
				if (op_text[k] == c) begin
					open_lexeme(MODE_OP, char_pos);
					op_held = 2'(k);
					return;
				end
			end
			if (is_digit(c)) begin
				open_lexeme(MODE_NUM, char_pos);
				lex_len = 1;
			end else if (c == CH_QUOTE) begin
				open_lexeme(MODE_STR, char_pos + 1'b1);
			end else if (is_alpha(c)) begin
				open_lexeme(MODE_IDENT, char_pos);
				kw_alive = '1;
				word_char(c);
			end else begin
				add_token(KIND_ERROR, char_pos, 1, 1'b0);
			end
		endfunction

		// Work out the tokens caused by one accepted item
		function void note_input(in_item_t it);
			logic [7:0]        c;
			logic [KIND_W-1:0] op_kind;
			int                first;
			out_item_t         t;
			c       = it.ch;
			op_kind = KIND_ASSIGN + KIND_W'(2 * op_held);
			first   = tokens_due.size();
			if (it.end_of_input) begin
				case (mode)
					MODE_OP:    add_token(op_kind, lex_start, 1, 1'b0);
					MODE_NUM:   add_token(KIND_INT, lex_start, lex_len, lex_sat);
					MODE_IDENT: add_token(word_kind(), lex_start, lex_len, lex_sat);
					MODE_STR:   add_token(KIND_ERROR, lex_start, lex_len, lex_sat);
					default:    ;
				endcase
				add_token(KIND_EOF, char_pos, 0, 1'b0);
				clear();
			end else begin
				case (mode)
					MODE_OP: begin
						mode = MODE_IDLE;
						if (c == CH_EQ) begin
							add_token(KIND_W'(op_kind + 1), lex_start, 2, 1'b0);
						end else begin
							add_token(op_kind, lex_start, 1, 1'b0);
							fresh_char(c);
						end
					end
					MODE_NUM: begin
						if (is_digit(c)) begin
							lengthen();
						end else begin
							add_token(KIND_INT, lex_start, lex_len, lex_sat);
							fresh_char(c);
						end
					end
					MODE_IDENT: begin
						if (is_alpha(c) || is_digit(c)) begin
							word_char(c);
						end else begin
							add_token(word_kind(), lex_start, lex_len, lex_sat);
							fresh_char(c);
						end
					end
					MODE_STR: begin
						if (c == CH_QUOTE) begin
							add_token(KIND_STRING, lex_start, lex_len, lex_sat);
							mode = MODE_IDLE;
						end else begin
							lengthen();
						end
					end
					default: fresh_char(c);
				endcase
				char_pos++;
			end
			// flag the final token of this item
			if (tokens_due.size() > first) begin
				t = tokens_due.pop_back();
				t.last_of_run = 1'b1;
				tokens_due.push_back(t);
			end
		endfunction

		function void mismatch(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_token(out_item_t got);
			out_item_t want;
			if (tokens_due.size() == 0) begin
				errors++;
				$display("%0t: token with none expected: expected nothing, actual %0h",
					$time, got);
				return;
			end
			want = tokens_due.pop_front();
			if (got.token_kind !== want.token_kind) begin
				mismatch("token_kind", want.token_kind, got.token_kind);
			end
			if (got.start_pos !== want.start_pos) begin
				mismatch("start_pos", want.start_pos, got.start_pos);
			end
			if (got.token_length !== want.token_length) begin
				mismatch("token_length", want.token_length, got.token_length);
			end
			if (got.length_saturated !== want.length_saturated) begin
				mismatch("length_saturated", want.length_saturated, got.length_saturated);
			end
			if (got.last_of_run !== want.last_of_run) begin
				mismatch("last_of_run", want.last_of_run, got.last_of_run);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_ready;
	in_item_t  src_item  = '0;
	logic      tok_valid;
	logic      tok_ready = 1'b0;
	out_item_t tok_item;

	token_tracker tracker = new();
	bit           idle_off = 1'b0;
	int           items_sent = 0;
	int           idle_cycles = 0;

	source_token_lexer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Token side: check accepted tokens, stall at random
	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready) begin
			tracker.check_token(tok_item);
		end
		tok_ready <= idle_off || ($urandom_range(99) >= 9);
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (tok_valid && tok_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_source_token_lexer_core: done, errors");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge that accepts the item
	task automatic send_item(in_item_t it);
		while (!idle_off && ($urandom_range(99) < 9)) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do @(posedge clk); while (!src_ready);
		tracker.note_input(it);
		items_sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		in_item_t it;
		it.ch           = c;
		it.end_of_input = 1'b0;
		send_item(it);
	endtask

	// End of input; the character byte is don't-care and left random
	task automatic send_end();
		in_item_t it;
		it.ch           = 8'($urandom_range(255));
		it.end_of_input = 1'b1;
		send_item(it);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(4) == 0) ? 8'("0" + $urandom_range(9)) : rand_letter();
	endfunction

	// Any byte a string may hold, with newlines made common
	function automatic logic [7:0] rand_text_byte();
		logic [7:0] c;
		if ($urandom_range(7) == 0) begin
			return CH_NL;
		end
		do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
		return c;
	endfunction

	function automatic logic [7:0] rand_space();
		int r;
		r = $urandom_range(2);
		return (r == 0) ? CH_SPACE : ((r == 1) ? CH_TAB : CH_NL);
	endfunction

	// One lexeme-shaped chunk of source, mostly well formed
	task automatic send_random_piece();
		int    pick;
		int    n;
		string kw;
		pick = $urandom_range(99);
		if (pick < 14) begin
			// keyword, sometimes cut short or extended
			kw = tracker.kw_word[$urandom_range(NUM_KW - 1)];
			n  = $urandom_range(3);
			if (n == 2) begin
				kw = kw.substr(0, $urandom_range(kw.len() - 1) - 1);
			end
			send_text(kw);
			if (n == 3) begin
				send_char(rand_alnum());
			end
		end else if (pick < 28) begin
			send_char(rand_letter());
			repeat ($urandom_range(7)) send_char(rand_alnum());
		end else if (pick < 40) begin
			repeat ($urandom_range(6, 1)) send_char(8'("0" + $urandom_range(9)));
		end else if (pick < 52) begin
			send_char(CH_QUOTE);
			repeat ($urandom_range(6)) send_char(rand_text_byte());
			if ($urandom_range(9) == 0) begin
				send_end();
			end else begin
				send_char(CH_QUOTE);
			end
		end else if (pick < 66) begin
			send_char(tracker.op_text[$urandom_range(3)]);
			if ($urandom_range(1)) begin
				send_char(CH_EQ);
			end
		end else if (pick < 78) begin
			send_char(tracker.sym_text[$urandom_range(9)]);
		end else if (pick < 88) begin
			send_char(rand_space());
		end else if (pick < 96) begin
			send_char(8'($urandom_range(255)));
		end else begin
			send_end();
		end
		if ($urandom_range(1)) begin
			send_char(rand_space());
		end
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		do @(posedge clk); while (tracker.tokens_due.size() != 0);
	endtask

	initial begin
		int mark;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: keyword then EOF, byte extremes, operators, strings
		send_text("int");
		send_end();
		send_char(8'h00);
		send_char(8'hFF);
		send_text("<=>!");
		send_end();
		send_text("\"a\n");
		send_end();
		send_text("7=(");
		send_end();
		send_text("\"\"==");
		send_end();

		// Random source text, with a stretch of no stalls on either side
		mark = items_sent;
		while (items_sent - mark < RANDOM_FIRST) begin
			idle_off = (items_sent - mark >= 150) && (items_sent - mark < 400);
			send_random_piece();
		end
		idle_off = 1'b0;
		wait_drained();

		// Long word and string after the drain, then an open operator at end of input
		send_text("false");
		repeat (12) send_char(rand_alnum());
		send_char(CH_SPACE);
		send_char(CH_QUOTE);
		repeat (20) send_char(rand_text_byte());
		send_char(CH_QUOTE);
		send_text("x1 =");
		send_end();

		mark = items_sent;
		while (items_sent - mark < RANDOM_SECOND) begin
			send_random_piece();
		end
		send_end();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.tokens_due.size() != 0) begin
			tracker.errors++;
			$display("%0t: tokens never seen: expected %0d more, actual 0", $time,
				tracker.tokens_due.size());
		end
		if (tracker.errors == 0) begin
			$display("tb_source_token_lexer_core: done, clean");
		end else begin
			$display("tb_source_token_lexer_core: done, errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/stl_pkg.sv
design/stl_front.sv
design/stl_queue.sv
design/stl_back.sv
design/source_token_lexer_core.sv
dv/tb_source_token_lexer_core.sv
